@@ src/dpc_pkg.sv @@
// shared types and constants of the deployment pulse controller
package dpc_pkg;

  // field widths
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned ALT_W       = 20;
  localparam int unsigned MIN_ALT_W   = 19;
  localparam int unsigned PULSE_W     = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 19;

  // default counter width
  localparam int unsigned TIMER_WIDTH_DEF = 16;

  // register reset values
  localparam logic [MIN_ALT_W-1:0] MIN_ALT_RESET = MIN_ALT_W'(1500);
  localparam logic [PULSE_W-1:0]   PULSE_RESET   = PULSE_W'(1000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAIN_MIN_ALT = 2'd0,
    REG_PULSE_LEN    = 2'd1
  } cfg_reg_t;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 3'd0,
    CMD_ARM         = 3'd1,
    CMD_SAFE        = 3'd2,
    CMD_FIRE_DROGUE = 3'd3,
    CMD_FIRE_MAIN   = 3'd4
  } cmd_t;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_ARMED = 2'd1,
    ST_SPENT     = 2'd2,
    ST_LOW       = 2'd3
  } status_t;

  // one result item as held in the output buffer
  typedef struct packed {
    status_t status;
    logic    drogue_drive;
    logic    main_drive;
    logic    armed_flag;
    logic    drogue_spent;
    logic    main_spent;
  } result_t;

endpackage

@@ src/dpc_in_if.sv @@
// command channel: valid, ready and one command item
interface dpc_in_if;
  logic                               valid;
  logic                               ready;
  logic [dpc_pkg::CMD_W-1:0]          command;
  logic signed [dpc_pkg::ALT_W-1:0]   altitude_dm;

  modport source (output valid, output command, output altitude_dm, input ready);
  modport sink (input valid, input command, input altitude_dm, output ready);
endinterface

@@ src/dpc_out_if.sv @@
// result channel: valid, ready and one status item
interface dpc_out_if;
  logic                               valid;
  logic                               ready;
  logic [dpc_pkg::STATUS_W-1:0]       status;
  logic                               drogue_drive;
  logic                               main_drive;
  logic                               armed_flag;
  logic                               drogue_spent;
  logic                               main_spent;

  modport source (output valid, output status, output drogue_drive, output main_drive,
                  output armed_flag, output drogue_spent, output main_spent, input ready);
  modport sink (input valid, input status, input drogue_drive, input main_drive,
                input armed_flag, input drogue_spent, input main_spent, output ready);
endinterface

@@ src/two_channel_deploy_pulse_controller_core.sv @@
// top level of the two-channel deployment pulse controller
//
// Usage: each command item (tick, arm, safe, fire drogue, fire main with
// altitude) arrives on in_ch and yields exactly one status item on out_ch,
// carrying the refusal status and the drive, armed and spent levels as they
// stand after that command. Ticks are expected once per millisecond.
// The cfg_ port writes the minimum main altitude (index 0) and the pulse
// length in ticks (index 1); write only while the block is idle.
// The status item is registered in the output register or skid entry.
// Throughput: one item per cycle while in_ch is ready; the state update
// is one pass of logic from the command handshake to the output register.
// A two-entry output buffer (output register plus skid entry) keeps in_ch
// ready while one finished item waits; in_ch.ready drops only when both
// entries are full, i.e. when out_ch has stalled for more than one item.
// Reset (rst_n low, synchronous) clears armed, drive and spent flags and the
// elapsed counters, empties the output buffer and restores the register
// defaults of 1500 dm and 1000 ticks.
module two_channel_deploy_pulse_controller_core #(
  parameter int unsigned TIMER_WIDTH = dpc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dpc_in_if.sink                          in_ch,
  dpc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dpc_pkg::*;

  // compare width covers both counter and pulse length
  localparam int unsigned CMP_W = (TIMER_WIDTH > PULSE_W) ? TIMER_WIDTH : PULSE_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  // configuration registers
  logic [MIN_ALT_W-1:0] min_alt_r;
  logic [PULSE_W-1:0]   pulse_len_r;

  // controller state
  logic                   armed_r, armed_nxt;
  logic                   drogue_active_r, drogue_active_nxt;
  logic                   main_active_r, main_active_nxt;
  logic                   drogue_used_r, drogue_used_nxt;
  logic                   main_used_r, main_used_nxt;
  logic [TIMER_WIDTH-1:0] drogue_elapsed_r, drogue_elapsed_nxt;
  logic [TIMER_WIDTH-1:0] main_elapsed_r, main_elapsed_nxt;

  // output buffer
  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;
  result_t res;
  status_t status;

  // tick helpers
  logic [TIMER_WIDTH-1:0] drogue_inc, main_inc;
  logic                   drogue_expire, main_expire;
  logic                   alt_low;
  logic                   push, pop;

  assign push = in_ch.valid & in_ch.ready;
  assign pop  = out_valid_r & out_ch.ready;
  assign in_ch.ready = ~skid_valid_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_alt_r   <= MIN_ALT_RESET;
      pulse_len_r <= PULSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAIN_MIN_ALT: min_alt_r   <= cfg_wdata[MIN_ALT_W-1:0];
        REG_PULSE_LEN:    pulse_len_r <= cfg_wdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // saturating counter advance and end-of-pulse detection
  assign drogue_inc = (drogue_elapsed_r == TIMER_MAX) ? drogue_elapsed_r
                                                      : drogue_elapsed_r + 1'b1;
  assign main_inc   = (main_elapsed_r == TIMER_MAX) ? main_elapsed_r
                                                    : main_elapsed_r + 1'b1;
  assign drogue_expire = (CMP_W'(drogue_inc) >= CMP_W'(pulse_len_r)) ||
                         (drogue_inc == TIMER_MAX);
  assign main_expire   = (CMP_W'(main_inc) >= CMP_W'(pulse_len_r)) ||
                         (main_inc == TIMER_MAX);

  // negative altitude is always below the limit
  assign alt_low = in_ch.altitude_dm[ALT_W-1] |
                   (in_ch.altitude_dm[MIN_ALT_W-1:0] < min_alt_r);

  // command decode and state update
  always_comb begin
    armed_nxt          = armed_r;
    drogue_active_nxt  = drogue_active_r;
    main_active_nxt    = main_active_r;
    drogue_used_nxt    = drogue_used_r;
    main_used_nxt      = main_used_r;
    drogue_elapsed_nxt = drogue_elapsed_r;
    main_elapsed_nxt   = main_elapsed_r;
    status             = ST_OK;
    case (in_ch.command)
      CMD_TICK: begin
        if (drogue_active_r) begin
          drogue_elapsed_nxt = drogue_inc;
          drogue_active_nxt  = ~drogue_expire;
        end
        if (main_active_r) begin
          main_elapsed_nxt = main_inc;
          main_active_nxt  = ~main_expire;
        end
      end
      CMD_ARM: armed_nxt = 1'b1;
      CMD_SAFE: begin
        armed_nxt         = 1'b0;
        drogue_active_nxt = 1'b0;
        main_active_nxt   = 1'b0;
      end
      CMD_FIRE_DROGUE: begin
        if (!armed_r) begin
          status = ST_NOT_ARMED;
        end else if (drogue_used_r) begin
          status = ST_SPENT;
        end else begin
          drogue_active_nxt  = 1'b1;
          drogue_used_nxt    = 1'b1;
          drogue_elapsed_nxt = '0;
        end
      end
      CMD_FIRE_MAIN: begin
        if (!armed_r) begin
          status = ST_NOT_ARMED;
        end else if (main_used_r) begin
          status = ST_SPENT;
        end else if (alt_low) begin
          status = ST_LOW;
        end else begin
          main_active_nxt  = 1'b1;
          main_used_nxt    = 1'b1;
          main_elapsed_nxt = '0;
        end
      end
      default: ;
    endcase
    res.status       = status;
    res.drogue_drive = drogue_active_nxt;
    res.main_drive   = main_active_nxt;
    res.armed_flag   = armed_nxt;
    res.drogue_spent = drogue_used_nxt;
    res.main_spent   = main_used_nxt;
  end

  // state registers, updated per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r          <= 1'b0;
      drogue_active_r  <= 1'b0;
      main_active_r    <= 1'b0;
      drogue_used_r    <= 1'b0;
      main_used_r      <= 1'b0;
      drogue_elapsed_r <= '0;
      main_elapsed_r   <= '0;
    end else if (push) begin
      armed_r          <= armed_nxt;
      drogue_active_r  <= drogue_active_nxt;
      main_active_r    <= main_active_nxt;
      drogue_used_r    <= drogue_used_nxt;
      main_used_r      <= main_used_nxt;
      drogue_elapsed_r <= drogue_elapsed_nxt;
      main_elapsed_r   <= main_elapsed_nxt;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
        out_data_r  <= res;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else begin
        skid_valid_r <= 1'b1;
        skid_data_r  <= res;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_data_r.status;
  assign out_ch.drogue_drive = out_data_r.drogue_drive;
  assign out_ch.main_drive   = out_data_r.main_drive;
  assign out_ch.armed_flag   = out_data_r.armed_flag;
  assign out_ch.drogue_spent = out_data_r.drogue_spent;
  assign out_ch.main_spent   = out_data_r.main_spent;

  // a driven output always belongs to a spent channel
  a_drogue_spent: assert property (@(posedge clk) disable iff (!rst_n)
    drogue_active_r |-> drogue_used_r) else $error("drogue driven but not spent");
  a_main_spent: assert property (@(posedge clk) disable iff (!rst_n)
    main_active_r |-> main_used_r) else $error("main driven but not spent");

  // skid entry only fills behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid entry holds item ahead of output");

  // an armed fire of a fresh drogue starts its pulse
  a_drogue_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_ch.command == CMD_FIRE_DROGUE && armed_r && !drogue_used_r)
    |=> (drogue_active_r && drogue_elapsed_r == '0))
    else $error("drogue fire did not start pulse");

  // safe drops everything
  a_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_ch.command == CMD_SAFE)
    |=> (!armed_r && !drogue_active_r && !main_active_r))
    else $error("safe left a channel armed or driven");

endmodule

@@ tb/sv/deploy_check_pkg.sv @@
// status tracker class: predicts the status item of each accepted command and checks it
package deploy_check_pkg;
  import dpc_pkg::*;

  localparam int unsigned TIMER_W = TIMER_WIDTH_DEF;

  class deploy_status_tracker;
    // configuration copy
    logic [MIN_ALT_W-1:0] min_alt;
    logic [PULSE_W-1:0]   pulse_len;

    // controller state copy
    bit                   armed;
    bit                   drogue_on;
    bit                   main_on;
    bit                   drogue_used;
    bit                   main_used;
    logic [TIMER_W-1:0]   drogue_ms;
    logic [TIMER_W-1:0]   main_ms;

    // status items still owed by the block, oldest first
    result_t              status_due[$];
    int unsigned          errors;

    function new();
      min_alt      = MIN_ALT_RESET;
      pulse_len    = PULSE_RESET;
      armed        = 1'b0;
      drogue_on    = 1'b0;
      main_on      = 1'b0;
      drogue_used  = 1'b0;
      main_used    = 1'b0;
      drogue_ms    = '0;
      main_ms      = '0;
      errors       = 0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    // register write, unknown indexes dropped
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAIN_MIN_ALT: min_alt = data[MIN_ALT_W-1:0];
        REG_PULSE_LEN:    pulse_len = data[PULSE_W-1:0];
        default: ;
      endcase
    endfunction

    // one millisecond for a driven channel, counter sticks at its top value
    function void age(inout bit on, inout logic [TIMER_W-1:0] ms);
      if (!on) return;
      if (ms != '1) ms = ms + 1'b1;
      if (ms >= pulse_len || ms == '1) on = 1'b0;
    endfunction

    // apply one accepted command and queue the status item it owes
    function void note_command(logic [CMD_W-1:0] cmd, logic signed [ALT_W-1:0] alt);
      result_t want;
      int      alt_i;
      int      min_i;
      alt_i = alt;
      min_i = min_alt;
      want.status = ST_OK;
      case (cmd)
        CMD_TICK: begin
          age(drogue_on, drogue_ms);
          age(main_on, main_ms);
        end
        CMD_ARM: armed = 1'b1;
        CMD_SAFE: begin
          armed     = 1'b0;
          drogue_on = 1'b0;
          main_on   = 1'b0;
        end
        CMD_FIRE_DROGUE: begin
          if (!armed) want.status = ST_NOT_ARMED;
          else if (drogue_used) want.status = ST_SPENT;
          else begin
            drogue_on    = 1'b1;
            drogue_used  = 1'b1;
            drogue_ms    = '0;
          end
        end
        CMD_FIRE_MAIN: begin
          // refusal order: not armed, spent, then altitude
          if (!armed) want.status = ST_NOT_ARMED;
          else if (main_used) want.status = ST_SPENT;
          else if (alt_i < min_i) want.status = ST_LOW;
          else begin
            main_on    = 1'b1;
            main_used  = 1'b1;
            main_ms    = '0;
          end
        end
        default: ;
      endcase
      want.drogue_drive = drogue_on;
      want.main_drive   = main_on;
      want.armed_flag   = armed;
      want.drogue_spent = drogue_used;
      want.main_spent   = main_used;
      status_due.push_back(want);
    endfunction

    // compare one accepted status item with the oldest owed one
    function void check_status(result_t got);
      result_t want;
      if (status_due.size() == 0) begin
        report("status item with nothing owed");
        return;
      end
      want = status_due.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.drogue_drive !== want.drogue_drive)
        report($sformatf("drogue_drive got %b want %b", got.drogue_drive, want.drogue_drive));
      if (got.main_drive !== want.main_drive)
        report($sformatf("main_drive got %b want %b", got.main_drive, want.main_drive));
      if (got.armed_flag !== want.armed_flag)
        report($sformatf("armed_flag got %b want %b", got.armed_flag, want.armed_flag));
      if (got.drogue_spent !== want.drogue_spent)
        report($sformatf("drogue_spent got %b want %b", got.drogue_spent, want.drogue_spent));
      if (got.main_spent !== want.main_spent)
        report($sformatf("main_spent got %b want %b", got.main_spent, want.main_spent));
    endfunction
  endclass

endpackage

@@ tb/sv/tb_two_channel_deploy_pulse_controller_core.sv @@
// top of the deployment pulse controller testbench: stimulus, handshakes and final verdict
module tb_two_channel_deploy_pulse_controller_core;
  import dpc_pkg::*;
  import deploy_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // codes the block must ignore
  localparam logic [CMD_W-1:0]     CMD_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3  = 2'd3;

  localparam int ALT_LO  = -(1 << (ALT_W - 1));
  localparam int ALT_HI  = (1 << (ALT_W - 1)) - 1;
  localparam int MAX_GAP = 13;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit                    calm;
  deploy_status_tracker  sb;

  dpc_in_if  in_ch ();
  dpc_out_if out_ch ();

  two_channel_deploy_pulse_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin : sample
    result_t seen;
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        sb.note_command(in_ch.command, in_ch.altitude_dm);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen.status       = status_t'(out_ch.status);
        seen.drogue_drive = out_ch.drogue_drive;
        seen.main_drive   = out_ch.main_drive;
        seen.armed_flag   = out_ch.armed_flag;
        seen.drogue_spent = out_ch.drogue_spent;
        seen.main_spent   = out_ch.main_spent;
        sb.check_status(seen);
      end
    end
  end

  // result side: random stall before each item
  initial begin : sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // one command item; starts and ends on a falling edge
  task automatic send(logic [CMD_W-1:0] cmd, logic signed [ALT_W-1:0] alt);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.command     = cmd;
    in_ch.altitude_dm = alt;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // register write once every owed item is back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_index = idx;
    cfg_wdata = data;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, data);
  endtask

  // random command; with hold_fires set no fire can succeed
  task automatic send_random(bit hold_fires);
    int unsigned              pick;
    int                       span;
    logic [CMD_W-1:0]         cmd;
    logic signed [ALT_W-1:0]  alt;
    pick = $urandom_range(0, 99);
    alt  = ALT_W'($urandom);
    if (pick < 30) cmd = CMD_TICK;
    else if (pick < 45) cmd = CMD_ARM;
    else if (pick < 53) cmd = CMD_SAFE;
    else if (pick < 68) cmd = CMD_FIRE_DROGUE;
    else if (pick < 88) cmd = CMD_FIRE_MAIN;
    else cmd = CMD_SPARE_LO + CMD_W'($urandom_range(0, 2));
    if (hold_fires && sb.armed) begin
      if (cmd == CMD_FIRE_DROGUE && !sb.drogue_used) cmd = CMD_TICK;
      // altitude strictly below the minimum
      if (cmd == CMD_FIRE_MAIN && !sb.main_used) begin
        span = int'(sb.min_alt) - 1 - ALT_LO;
        alt  = ALT_W'(ALT_LO + int'($urandom_range(0, span)));
      end
    end
    send(cmd, alt);
  endtask

  task automatic random_phase(int unsigned count, bit hold_fires);
    for (int unsigned i = 0; i < count; i++) begin
      // occasional stretches with no idling on either side
      if (i % 60 == 0) calm = ($urandom_range(0, 4) == 0);
      send_random(hold_fires);
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned min_pick;
    sb                = new();
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_TICK;
    in_ch.altitude_dm = '0;
    cfg_we            = 1'b0;
    cfg_index         = REG_MAIN_MIN_ALT;
    cfg_wdata         = '0;
    calm              = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // refusals and ignored codes with the reset settings
    send(CMD_FIRE_DROGUE, '0);
    send(CMD_FIRE_MAIN, ALT_W'(ALT_HI));
    send(CMD_SPARE_LO, ALT_W'(ALT_HI));
    send(CMD_SPARE_LO + 3'd1, '0);
    send(CMD_SPARE_LO + 3'd2, ALT_W'(ALT_LO));
    send(CMD_TICK, ALT_W'(ALT_LO));
    send(CMD_SAFE, '0);
    send(CMD_ARM, '0);
    send(CMD_ARM, '0);
    send(CMD_FIRE_MAIN, ALT_W'(ALT_LO));
    send(CMD_FIRE_MAIN, ALT_W'(-1));
    send(CMD_FIRE_MAIN, ALT_W'(int'(MIN_ALT_RESET) - 1));
    send(CMD_TICK, '0);
    send(CMD_SAFE, '0);
    send(CMD_FIRE_MAIN, ALT_W'(int'(MIN_ALT_RESET)));
    send(CMD_FIRE_DROGUE, '0);

    // altitude refusals at the highest and lowest minimum
    write_reg(REG_MAIN_MIN_ALT, CFG_DATA_W'((1 << MIN_ALT_W) - 1));
    write_reg(REG_PULSE_LEN, CFG_DATA_W'(1));
    random_phase(300, 1'b1);
    write_reg(REG_MAIN_MIN_ALT, '0);
    write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
    random_phase(300, 1'b1);

    // drogue with zero pulse length drops on the first tick
    write_reg(REG_PULSE_LEN, '0);
    send(CMD_ARM, '0);
    send(CMD_FIRE_DROGUE, '0);
    send(CMD_TICK, '0);
    send(CMD_FIRE_DROGUE, '0);
    send(CMD_SAFE, '0);
    send(CMD_FIRE_DROGUE, '0);

    // main at exactly the minimum, then its pulse runs out on ticks
    min_pick = $urandom_range(1, (1 << MIN_ALT_W) - 1);
    write_reg(REG_MAIN_MIN_ALT, CFG_DATA_W'(min_pick));
    write_reg(REG_PULSE_LEN, CFG_DATA_W'(24));
    send(CMD_ARM, '0);
    send(CMD_FIRE_MAIN, ALT_W'(int'(min_pick) - 1));
    send(CMD_FIRE_MAIN, ALT_W'(int'(min_pick)));
    send(CMD_FIRE_MAIN, ALT_W'(int'(min_pick)));
    calm = 1'b1;
    repeat (32) send(CMD_TICK, ALT_W'($urandom));
    calm = 1'b0;

    // both channels spent: free random traffic under several settings
    write_reg(REG_MAIN_MIN_ALT, CFG_DATA_W'($urandom));
    write_reg(REG_PULSE_LEN, CFG_DATA_W'($urandom));
    random_phase(240, 1'b0);
    write_reg(REG_MAIN_MIN_ALT, CFG_DATA_W'(MIN_ALT_RESET));
    write_reg(REG_PULSE_LEN, CFG_DATA_W'(1));
    random_phase(240, 1'b0);
    write_reg(REG_MAIN_MIN_ALT, CFG_DATA_W'($urandom));
    write_reg(REG_PULSE_LEN, CFG_DATA_W'($urandom_range(1, 8)));
    random_phase(240, 1'b0);

    // drain
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ two_channel_deploy_pulse_controller_core.f @@
src/dpc_pkg.sv
src/dpc_in_if.sv
src/dpc_out_if.sv
src/two_channel_deploy_pulse_controller_core.sv
tb/sv/deploy_check_pkg.sv
tb/sv/tb_two_channel_deploy_pulse_controller_core.sv
